### hdl/gsc_pkg.sv
`timescale 1ns / 1ps
package gsc_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL_S,
		ST_MUL_V,
		ST_SUM,
		ST_ROUND,
		ST_MUL_SC,
		ST_SCALE,
		ST_DONE
	} state_t;

	localparam int K_W    = 27;
	localparam int D_W    = 32;
	localparam int PROD_W = K_W + 1 + D_W;

	typedef struct packed {
		logic                  en;
		logic [K_W-1:0]        k;
		logic signed [D_W-1:0] d;
	} mul_req_t;

	// low-pass coefficients in q16
	localparam logic [K_W-1:0] K_ONE_MINUS_ALPHA = 27'd64323;
	localparam logic [K_W-1:0] K_ALPHA           = 27'd1213;
	// 175/610 as 35 * ceil(2^28 / 122), exact for magnitudes up to 32768
	localparam logic [K_W-1:0] K_SCALE           = 27'd77010185;
	localparam int             LP_SHIFT          = 16;
	localparam int             SCALE_SHIFT       = 28;

	localparam logic signed [16:0] SLEW_LIMIT = 17'sd2000;
	localparam logic [16:0]        RATE_MAX   = 17'd32767;
	localparam logic [33:0]        ROUND_HALF = 34'd32768;

	localparam logic [2:0] CFG_OFFSET_X    = 3'd0;
	localparam logic [2:0] CFG_OFFSET_Y    = 3'd1;
	localparam logic [2:0] CFG_OFFSET_Z    = 3'd2;
	localparam logic [2:0] CFG_FILTER_EN   = 3'd3;
	localparam logic [2:0] CFG_ENGAGE_MODE = 3'd4;
	localparam logic [2:0] CFG_OUTPUT_MODE = 3'd5;
	localparam logic [2:0] CFG_BUTTON_MASK = 3'd6;
	localparam logic [2:0] CFG_DPAD_MASK   = 3'd7;

	localparam logic [1:0] ENG_ALWAYS = 2'd0;
	localparam logic [1:0] ENG_HOLD   = 2'd1;
	localparam logic [1:0] ENG_PAUSE  = 2'd2;

	localparam logic [1:0] OUT_REPORT = 2'd0;

	localparam logic [1:0] AXIS_LAST = 2'd2;

endpackage

### hdl/gsc_mul.sv
`timescale 1ns / 1ps
module gsc_mul (
	input  logic                                   clk,
	input  gsc_pkg::mul_req_t                      req,
	output logic signed [gsc_pkg::PROD_W-1:0]      prod
);
	import gsc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= $signed({1'b0, req.k}) * req.d;
		end
	end

	assign prod = prod_q;

endmodule

### hdl/gyro_sample_conditioner_unit.sv
`timescale 1ns / 1ps
// gyro sample conditioner
// input stream s_*: one transaction carries a gyro sample (x, y, z), the
// accelerometer sample and the current button and dpad bits. per axis the
// zero-rate offset is removed, an optional slew limiter and an optional
// one-pole low-pass run, and the rate is scaled to report units.
// output stream m_*: one transaction per input when the engage rule passes
// and output mode is the controller report; otherwise the input only
// advances the filter state.
// configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
// sequencing: the three axes go one after another through one shared
// multiplier. with the low-pass on an axis steps through prep, mul_s,
// mul_v, sum, round, mul_sc and scale; with it off through prep, mul_sc
// and scale. a new input is taken only once the sequencer is back in idle.
// s_tready is high only while the sequencer is idle. a finished result waits
// in the output register; a stalled receiver holds the sequencer only when
// the next result is ready and the register is still full.
// reset clears configuration, slew and low-pass state and the output valid.
module gyro_sample_conditioner_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_in_x, accel_in_y, accel_in_z,
	// button_bits, dpad_bits, zero fill
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rate_out_x, rate_out_y, rate_out_z, accel_out_x, accel_out_y, accel_out_z
	output logic [95:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	import gsc_pkg::*;

	state_t state_q, state_nxt;
	logic [1:0] axis_q;

	logic signed [15:0] offset_q [3];
	logic [1:0]  filter_en_q, engage_mode_q, output_mode_q;
	logic [31:0] button_mask_q;
	logic [3:0]  dpad_mask_q;

	logic signed [15:0] prev_q [3];
	logic signed [31:0] smooth_q [3];

	logic [131:0] in_q;
	logic signed [15:0] v_q;
	logic signed [PROD_W-LP_SHIFT-1:0] acc_q;
	logic signed [32:0] snew_q;
	logic neg_sc_q;
	logic signed [15:0] rate_q [3];

	logic        m_tvalid_q;
	logic [95:0] m_tdata_q;

	mul_req_t mul_req;
	logic signed [PROD_W-1:0] prod;

	logic signed [15:0] raw_sel, off_sel, prev_sel, g_wrap, slew_val;
	logic signed [31:0] smooth_sel;
	logic signed [16:0] diff, d_clamp, prev_sum;
	logic [33:0] s_sum;
	logic [32:0] s_mag;
	logic [33:0] s_rnd;
	logic [16:0] r_mag, r_neg, v_mag;
	logic [15:0] v_round, q_sc, rate_val;
	logic held, run, emit, out_free, load_out;

	gsc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// axis operand selection
	always_comb begin
		case (axis_q)
			2'd0: begin
				raw_sel    = in_q[15:0];
				off_sel    = offset_q[0];
				prev_sel   = prev_q[0];
				smooth_sel = smooth_q[0];
			end
			2'd1: begin
				raw_sel    = in_q[31:16];
				off_sel    = offset_q[1];
				prev_sel   = prev_q[1];
				smooth_sel = smooth_q[1];
			end
			default: begin
				raw_sel    = in_q[47:32];
				off_sel    = offset_q[2];
				prev_sel   = prev_q[2];
				smooth_sel = smooth_q[2];
			end
		endcase
	end

	// offset and slew limit
	always_comb begin
		g_wrap = raw_sel - off_sel;
		diff   = {g_wrap[15], g_wrap} - {prev_sel[15], prev_sel};
		if (diff > SLEW_LIMIT) begin
			d_clamp = SLEW_LIMIT;
		end else if (diff < -SLEW_LIMIT) begin
			d_clamp = -SLEW_LIMIT;
		end else begin
			d_clamp = diff;
		end
		prev_sum = {prev_sel[15], prev_sel} + d_clamp;
		slew_val = prev_sum[15:0];
	end

	// low-pass sum, rounding, scaling
	always_comb begin
		s_sum   = acc_q[33:0] + prod[33:0];
		s_mag   = snew_q[32] ? 33'(-snew_q) : 33'(snew_q);
		s_rnd   = {1'b0, s_mag} + ROUND_HALF;
		r_mag   = s_rnd[32:16];
		r_neg   = 17'(-r_mag);
		if (snew_q[32]) begin
			v_round = r_neg[15:0];
		end else if (r_mag > RATE_MAX) begin
			v_round = RATE_MAX[15:0];
		end else begin
			v_round = r_mag[15:0];
		end
		v_mag    = v_q[15] ? 17'(-{v_q[15], v_q}) : 17'({v_q[15], v_q});
		q_sc     = prod[SCALE_SHIFT +: 16];
		rate_val = neg_sc_q ? 16'(-q_sc) : q_sc;
	end

	always_comb begin
		held = (|(in_q[127:96] & button_mask_q)) || (|(in_q[131:128] & dpad_mask_q));
		run  = (engage_mode_q == ENG_ALWAYS) || ((engage_mode_q == ENG_HOLD) && held) ||
			((engage_mode_q == ENG_PAUSE) && !held);
		emit     = run && (output_mode_q == OUT_REPORT);
		out_free = !m_tvalid_q || m_tready;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_nxt = ST_PREP;
			end
			ST_PREP: begin
				state_nxt = filter_en_q[1] ? ST_MUL_S : ST_MUL_SC;
			end
			ST_MUL_S:  state_nxt = ST_MUL_V;
			ST_MUL_V:  state_nxt = ST_SUM;
			ST_SUM:    state_nxt = ST_ROUND;
			ST_ROUND:  state_nxt = ST_MUL_SC;
			ST_MUL_SC: state_nxt = ST_SCALE;
			ST_SCALE: begin
				state_nxt = (axis_q == AXIS_LAST) ? ST_DONE : ST_PREP;
			end
			ST_DONE: begin
				if (!emit || out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		mul_req  = '0;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_MUL_S: begin
				mul_req.en = 1'b1;
				mul_req.k  = K_ONE_MINUS_ALPHA;
				mul_req.d  = smooth_sel;
			end
			ST_MUL_V: begin
				mul_req.en = 1'b1;
				mul_req.k  = K_ALPHA;
				mul_req.d  = {{16{v_q[15]}}, v_q};
			end
			ST_MUL_SC: begin
				mul_req.en = 1'b1;
				mul_req.k  = K_SCALE;
				mul_req.d  = {15'd0, v_mag};
			end
			ST_DONE: load_out = emit && out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 2'd0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE:  axis_q <= 2'd0;
				ST_SCALE: axis_q <= axis_q + 2'd1;
				default: ;
			endcase
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) offset_q[i] <= '0;
			filter_en_q   <= '0;
			engage_mode_q <= '0;
			output_mode_q <= '0;
			button_mask_q <= '0;
			dpad_mask_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET_X:    offset_q[0]   <= cfg_wdata[15:0];
				CFG_OFFSET_Y:    offset_q[1]   <= cfg_wdata[15:0];
				CFG_OFFSET_Z:    offset_q[2]   <= cfg_wdata[15:0];
				CFG_FILTER_EN:   filter_en_q   <= cfg_wdata[1:0];
				CFG_ENGAGE_MODE: engage_mode_q <= cfg_wdata[1:0];
				CFG_OUTPUT_MODE: output_mode_q <= cfg_wdata[1:0];
				CFG_BUTTON_MASK: button_mask_q <= cfg_wdata;
				CFG_DPAD_MASK:   dpad_mask_q   <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prev_q[i]   <= '0;
				smooth_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_PREP && filter_en_q[0]) prev_q[axis_q] <= slew_val;
			if (state_q == ST_SUM) smooth_q[axis_q] <= s_sum[31:0];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) in_q <= s_tdata[131:0];
			end
			ST_PREP:  v_q <= filter_en_q[0] ? slew_val : g_wrap;
			ST_MUL_V: acc_q <= prod[PROD_W-1:LP_SHIFT];
			ST_SUM:   snew_q <= s_sum[32:0];
			ST_ROUND: v_q <= v_round;
			ST_MUL_SC: neg_sc_q <= v_q[15];
			ST_SCALE: rate_q[axis_q] <= rate_val;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) m_tdata_q <= {in_q[95:48], rate_q[2], rate_q[1], rate_q[0]};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_PREP && axis_q == 2'd0))
		else $error("sequencer did not start on axis x");

	a_emit_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside done state");

	a_emit_mode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(output_mode_q == OUT_REPORT))
		else $error("result given in a non-report output mode");

	a_rate_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000 &&
			m_tdata[47:32] != 16'h8000))
		else $error("scaled rate out of range");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_SC) |=> (state_q == ST_SCALE && !s_tready))
		else $error("scale step skipped");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import gsc_pkg::*;

	localparam logic [1:0] ENG_NEVER       = 2'd3;
	localparam logic [1:0] OUT_LEFT_STICK  = 2'd1;
	localparam logic [1:0] OUT_RIGHT_STICK = 2'd2;
	localparam logic [1:0] OUT_MOUSE       = 2'd3;
	localparam logic [1:0] FEN_SLEW        = 2'b01;
	localparam logic [1:0] FEN_SMOOTH      = 2'b10;

	localparam int SLEW_STEP   = 2000;
	localparam int LP_GAIN     = 1213;
	localparam int LP_KEEP     = 64323;
	localparam int SCALE_MUL   = 175;
	localparam int SCALE_DIV   = 610;
	localparam int REPORT_MAX  = 32767;
	localparam int SETTLE_CYC  = 48;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 84;

	typedef struct packed {
		logic [3:0]         zero_fill;
		logic [3:0]         dpad;
		logic [31:0]        buttons;
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
		logic signed [15:0] gz;
		logic signed [15:0] gy;
		logic signed [15:0] gx;
	} gyro_sample_t;

	typedef struct packed {
		logic signed [15:0] az;
		logic signed [15:0] ay;
		logic signed [15:0] ax;
		logic signed [15:0] rz;
		logic signed [15:0] ry;
		logic signed [15:0] rx;
	} gyro_report_t;

	typedef struct packed {
		logic signed [15:0] off_x;
		logic signed [15:0] off_y;
		logic signed [15:0] off_z;
		logic [1:0]         fen;
		logic [1:0]         eng;
		logic [1:0]         outm;
		logic [31:0]        bmask;
		logic [3:0]         dmask;
	} cfg_set_t;

	class gyro_report_model;
		logic signed [15:0] offset [3];
		logic [1:0]         filter_en;
		logic [1:0]         engage;
		logic [1:0]         out_mode;
		logic [31:0]        button_mask;
		logic [3:0]         dpad_mask;
		logic signed [15:0] slew_prev [3];
		int                 smooth_acc [3];
		gyro_report_t       expected_reports [$];
		int                 errors;
		int                 samples_seen;
		int                 reports_seen;

		function new();
			for (int i = 0; i < 3; i++) begin
				offset[i] = '0;
				slew_prev[i] = '0;
				smooth_acc[i] = 0;
			end
			filter_en = '0;
			engage = '0;
			out_mode = '0;
			button_mask = '0;
			dpad_mask = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				CFG_OFFSET_X:    offset[0] = val[15:0];
				CFG_OFFSET_Y:    offset[1] = val[15:0];
				CFG_OFFSET_Z:    offset[2] = val[15:0];
				CFG_FILTER_EN:   filter_en = val[1:0];
				CFG_ENGAGE_MODE: engage = val[1:0];
				CFG_OUTPUT_MODE: out_mode = val[1:0];
				CFG_BUTTON_MASK: button_mask = val;
				CFG_DPAD_MASK:   dpad_mask = val[3:0];
				default: ;
			endcase
		endfunction

		function void note_sample(gyro_sample_t smp);
			logic signed [15:0] raw [3];
			logic signed [15:0] g16;
			logic [15:0]        rate [3];
			int                 g;
			int                 d;
			longint             prod;
			longint             acc;
			longint             mag;
			longint             r;
			logic               held;
			logic               run;
			gyro_report_t       rep;
			raw[0] = smp.gx;
			raw[1] = smp.gy;
			raw[2] = smp.gz;
			samples_seen++;
			for (int i = 0; i < 3; i++) begin
				g16 = raw[i] - offset[i];
				g = int'(g16);
				if (filter_en & FEN_SLEW) begin
					d = g - int'(slew_prev[i]);
					if (d > SLEW_STEP)
						d = SLEW_STEP;
					if (d < -SLEW_STEP)
						d = -SLEW_STEP;
					slew_prev[i] = 16'(int'(slew_prev[i]) + d);
					g = int'(slew_prev[i]);
				end
				if (filter_en & FEN_SMOOTH) begin
					prod = longint'(LP_KEEP) * longint'(smooth_acc[i]);
					acc = longint'(LP_GAIN) * longint'(g) + (prod >>> 16);
					smooth_acc[i] = int'(acc);
					mag = (acc < 0) ? -acc : acc;
					r = (mag + 32768) >>> 16;
					if (acc < 0)
						r = -r;
					if (r > 32767)
						r = 32767;
					if (r < -32768)
						r = -32768;
					g = int'(r);
				end
				mag = (g < 0) ? -longint'(g) : longint'(g);
				r = mag * SCALE_MUL / SCALE_DIV;
				if (g < 0)
					r = -r;
				if (r > REPORT_MAX)
					r = REPORT_MAX;
				if (r < -REPORT_MAX)
					r = -REPORT_MAX;
				rate[i] = r[15:0];
			end
			held = (|(smp.buttons & button_mask)) || (|(smp.dpad & dpad_mask));
			case (engage)
				ENG_ALWAYS: run = 1'b1;
				ENG_HOLD:   run = held;
				ENG_PAUSE:  run = !held;
				default:    run = 1'b0;
			endcase
			if (run && out_mode == OUT_REPORT) begin
				rep.rx = rate[0];
				rep.ry = rate[1];
				rep.rz = rate[2];
				rep.ax = smp.ax;
				rep.ay = smp.ay;
				rep.az = smp.az;
				expected_reports.push_back(rep);
			end
		endfunction

		function void compare(string name, logic [15:0] exp, logic [15:0] act);
			if (exp !== act) begin
				$error("%s mismatch: expected %0d, actual %0d", name, $signed(exp), $signed(act));
				errors++;
			end
		endfunction

		function void check_report(gyro_report_t got);
			gyro_report_t exp;
			reports_seen++;
			if (expected_reports.size() == 0) begin
				$error("unexpected report transaction: rate_out_x %0d", got.rx);
				errors++;
			end else begin
				exp = expected_reports.pop_front();
				compare("rate_out_x", exp.rx, got.rx);
				compare("rate_out_y", exp.ry, got.ry);
				compare("rate_out_z", exp.rz, got.rz);
				compare("accel_out_x", exp.ax, got.ax);
				compare("accel_out_y", exp.ay, got.ay);
				compare("accel_out_z", exp.az, got.az);
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_in_x, accel_in_y, accel_in_z,
	// button_bits, dpad_bits, zero fill
	logic [135:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// rate_out_x, rate_out_y, rate_out_z, accel_out_x, accel_out_y, accel_out_z
	logic [95:0]  m_tdata;
	logic         cfg_we = 1'b0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	gyro_report_model model;
	gyro_sample_t     stim_q [$];
	bit               no_idle = 1'b0;
	int               phases = 0;

	gyro_sample_conditioner_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic gyro_sample_t mk(int gx, int gy, int gz, int ax, int ay, int az,
			logic [31:0] btn, logic [3:0] dpad);
		gyro_sample_t s;
		s.zero_fill = '0;
		s.gx = gx[15:0];
		s.gy = gy[15:0];
		s.gz = gz[15:0];
		s.ax = ax[15:0];
		s.ay = ay[15:0];
		s.az = az[15:0];
		s.buttons = btn;
		s.dpad = dpad;
		return s;
	endfunction

	function automatic logic signed [15:0] next_axis(logic signed [15:0] prev);
		logic signed [15:0] v;
		case ($urandom % 8)
			0, 1, 2, 3: v = prev + 16'($urandom_range(0, 6000) - 3000);
			4, 5:       v = 16'($urandom);
			6:          v = ($urandom % 2) ? 16'sh7fff : 16'sh8000;
			default:    v = prev;
		endcase
		return v;
	endfunction

	function automatic gyro_sample_t random_sample(gyro_sample_t prev);
		gyro_sample_t s;
		s.zero_fill = '0;
		s.gx = next_axis(prev.gx);
		s.gy = next_axis(prev.gy);
		s.gz = next_axis(prev.gz);
		s.ax = 16'($urandom);
		s.ay = 16'($urandom);
		s.az = 16'($urandom);
		case ($urandom % 4)
			0:       s.buttons = '0;
			1:       s.buttons = $urandom;
			default: s.buttons = $urandom & $urandom & $urandom & $urandom;
		endcase
		s.dpad = 4'($urandom);
		return s;
	endfunction

	function automatic logic signed [15:0] random_offset();
		case ($urandom % 4)
			0:       return '0;
			1:       return 16'($urandom_range(0, 1000) - 500);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfg_set_t random_settings();
		cfg_set_t c;
		int       r;
		c.off_x = random_offset();
		c.off_y = random_offset();
		c.off_z = random_offset();
		c.fen = 2'($urandom_range(0, 3));
		r = $urandom % 10;
		if (r < 6)
			c.eng = ENG_ALWAYS;
		else if (r < 8)
			c.eng = ENG_HOLD;
		else if (r < 9)
			c.eng = ENG_PAUSE;
		else
			c.eng = ENG_NEVER;
		c.outm = ($urandom % 8 == 0) ? 2'($urandom_range(1, 3)) : OUT_REPORT;
		c.bmask = (32'd1 << ($urandom % 32)) | (($urandom % 2) ? ($urandom & $urandom) : 32'd0);
		c.dmask = 4'($urandom);
		return c;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		model.set_reg(idx, val);
	endtask

	task automatic apply_settings(input cfg_set_t c);
		write_reg(CFG_OFFSET_X, {16'd0, c.off_x});
		write_reg(CFG_OFFSET_Y, {16'd0, c.off_y});
		write_reg(CFG_OFFSET_Z, {16'd0, c.off_z});
		write_reg(CFG_FILTER_EN, {30'd0, c.fen});
		write_reg(CFG_ENGAGE_MODE, {30'd0, c.eng});
		write_reg(CFG_OUTPUT_MODE, {30'd0, c.outm});
		write_reg(CFG_BUTTON_MASK, c.bmask);
		write_reg(CFG_DPAD_MASK, {28'd0, c.dmask});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_stimulus();
		int           gap;
		gyro_sample_t smp;
		while (stim_q.size() > 0) begin
			smp = stim_q.pop_front();
			gap = no_idle ? 0 : $urandom_range(0, 16);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= smp;
			do @(posedge clk); while (s_tready !== 1'b1);
			model.note_sample(smp);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (model.expected_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic run_phase(input cfg_set_t c);
		apply_settings(c);
		send_stimulus();
		wait_drained();
		phases++;
	endtask

	// receiver with random backpressure
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			model.check_report(m_tdata);
		end
	end

	initial begin
		cfg_set_t     c;
		gyro_sample_t last;
		gyro_sample_t held_set [4];
		model = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, no filtering
		c = '0;
		stim_q.push_back(mk(-32768, 32767, 0, -32768, 32767, -1, 32'h0, 4'h0));
		stim_q.push_back(mk(32767, -32768, -1, 32767, -32768, 0, 32'hffff_ffff, 4'hf));
		stim_q.push_back(mk(1, -1, -32767, 0, 1, -2, 32'h5555_5555, 4'h5));
		run_phase(c);

		// offset wrap with slew limiting
		c.off_x = 16'sh7fff;
		c.off_y = 16'sh8000;
		c.off_z = 16'sd1;
		c.fen = FEN_SLEW;
		stim_q.push_back(mk(-32768, 32767, -32768, 100, 200, 300, 32'h0, 4'h0));
		stim_q.push_back(mk(32767, -32768, 32767, -100, -200, -300, 32'h0, 4'h0));
		stim_q.push_back(mk(0, 0, 0, 1, 2, 3, 32'h0, 4'h0));
		stim_q.push_back(mk(5000, -5000, 100, 4, 5, 6, 32'h0, 4'h0));
		run_phase(c);

		// both filters at full scale
		c = '0;
		c.fen = FEN_SLEW | FEN_SMOOTH;
		repeat (4) stim_q.push_back(mk(-32768, 32767, 1500, 7, 8, 9, 32'h0, 4'h0));
		repeat (2) stim_q.push_back(mk(32767, -32768, 0, -7, -8, -9, 32'h0, 4'h0));
		run_phase(c);

		// engage key held and paused
		held_set[0] = mk(400, -400, 9000, 11, 12, 13, 32'h0, 4'h0);
		held_set[1] = mk(-20000, 20000, 1, 14, 15, 16, 32'h8000_0000, 4'h0);
		held_set[2] = mk(32767, -32768, -1, 17, 18, 19, 32'h0, 4'h4);
		held_set[3] = mk(-32768, 32767, 0, 20, 21, 22, 32'h7fff_fffe, 4'hb);
		c.fen = FEN_SMOOTH;
		c.eng = ENG_HOLD;
		c.bmask = 32'h8000_0001;
		c.dmask = 4'h4;
		foreach (held_set[i]) stim_q.push_back(held_set[i]);
		run_phase(c);
		c.eng = ENG_PAUSE;
		foreach (held_set[i]) stim_q.push_back(held_set[i]);
		run_phase(c);

		// unused engage mode and non-report output mode give no result
		c.eng = ENG_NEVER;
		stim_q.push_back(held_set[1]);
		stim_q.push_back(held_set[0]);
		run_phase(c);
		c.eng = ENG_ALWAYS;
		c.outm = OUT_MOUSE;
		stim_q.push_back(held_set[2]);
		run_phase(c);

		last = '0;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			c = random_settings();
			if (ph == 0) begin
				c.off_x = 16'sh8000;
				c.off_y = 16'sh8000;
				c.off_z = 16'sh8000;
				c.fen = FEN_SLEW | FEN_SMOOTH;
				c.eng = ENG_ALWAYS;
				c.outm = OUT_REPORT;
				c.bmask = 32'hffff_ffff;
				c.dmask = 4'hf;
			end else if (ph == 1) begin
				c.off_x = 16'sh7fff;
				c.off_y = 16'sh7fff;
				c.off_z = 16'sh7fff;
				c.fen = FEN_SLEW;
				c.eng = ENG_PAUSE;
				c.outm = OUT_REPORT;
				c.bmask = '0;
				c.dmask = '0;
			end
			no_idle = (ph % 4 == 3);
			repeat (PHASE_ITEMS) begin
				last = random_sample(last);
				stim_q.push_back(last);
			end
			run_phase(c);
		end
		no_idle = 1'b0;

		wait_drained();
		$display("covered %0d gyro samples over %0d configuration phases", model.samples_seen,
			phases);
		$display("compared %0d report transactions with the predicted rates", model.reports_seen);
		if (model.errors == 0 && model.expected_reports.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### gyro_sample_conditioner_unit.f
hdl/gsc_pkg.sv
hdl/gsc_mul.sv
hdl/gyro_sample_conditioner_unit.sv
bench/testbench.sv
